### rtl/mipc_pkg.sv
`default_nettype none

package mipc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CH_W     = 3;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned ERR_W    = VAL_W + 1;
  localparam int unsigned PROD_W   = VAL_W + 1 + ERR_W;
  localparam int unsigned CFG_IDX_W = 3;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SUM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_CHANNEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_VALUE   = 3'd5;

  // Register values after reset
  localparam logic [VAL_W-1:0] RST_GAIN_SUM      = 16'd4096;
  localparam logic [VAL_W-1:0] RST_GAIN_PROP     = 16'd1229;
  localparam logic [VAL_W-1:0] RST_OFF_THRESHOLD = 16'd410;
  localparam logic [VAL_W-1:0] RST_OUTPUT_LIMIT  = 16'd3000;
  localparam logic [CH_W-1:0]  RST_FIXED_CHANNEL = 3'd6;
  localparam logic [VAL_W-1:0] RST_FIXED_VALUE   = 16'd5000;

  // How an update is carried out
  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_FIXED = 2'd1,
    KIND_REG   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [VAL_W-1:0] gain_sum;
    logic [VAL_W-1:0] gain_prop;
    logic [VAL_W-1:0] off_threshold;
    logic [VAL_W-1:0] output_limit;
    logic [CH_W-1:0]  fixed_channel;
    logic [VAL_W-1:0] fixed_value;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    kind_t                   kind;
    logic signed [ERR_W-1:0] err;
  } item_t;

endpackage

`default_nettype wire

### rtl/mipc_front.sv
`default_nettype none

module mipc_front #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mipc_pkg::cfg_t                 cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mipc_pkg::CH_W-1:0]      in_channel,
  input  wire logic [mipc_pkg::VAL_W-1:0]     in_setpoint,
  input  wire logic [mipc_pkg::VAL_W-1:0]     in_measurement,
  output logic                                push,
  output mipc_pkg::item_t                     push_item,
  input  wire logic                           push_ready
);

  logic            f_v_r;
  mipc_pkg::item_t f_item_r;
  mipc_pkg::item_t f_item_nxt;
  logic            accept;
  logic            ch_ok;

  // Hold the classified item until the queue takes it
  assign push      = f_v_r && push_ready;
  assign push_item = f_item_r;
  assign in_ready  = !f_v_r || push_ready;
  assign accept    = in_valid && in_ready;

  // Classify the update and form the error
  assign ch_ok = (32'(in_channel) < CHANNELS);

  always_comb begin
    f_item_nxt.ch  = in_channel;
    f_item_nxt.err = $signed({1'b0, in_setpoint}) - $signed({1'b0, in_measurement});
    if (!ch_ok || (in_setpoint < cfg.off_threshold)) begin
      f_item_nxt.kind = mipc_pkg::KIND_ZERO;
    end else if (in_channel == cfg.fixed_channel) begin
      f_item_nxt.kind = mipc_pkg::KIND_FIXED;
    end else begin
      f_item_nxt.kind = mipc_pkg::KIND_REG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (accept) begin
      f_v_r <= 1'b1;
    end else if (push) begin
      f_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/mipc_queue.sv
`default_nettype none

module mipc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mipc_pkg::item_t push_item,
  output logic                 push_ready,
  output logic                 pop_valid,
  output mipc_pkg::item_t      pop_item,
  input  wire logic            pop
);

  localparam int unsigned DEPTH = mipc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mipc_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];

  // Wrap the pointers at the depth
  assign wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### rtl/mipc_back.sv
`default_nettype none

module mipc_back #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mipc_pkg::cfg_t              cfg,
  input  wire logic                        q_valid,
  input  wire mipc_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mipc_pkg::CH_W-1:0]        out_channel,
  output logic [mipc_pkg::VAL_W-1:0]       out_control_out
);

  localparam int unsigned VAL_W  = mipc_pkg::VAL_W;
  localparam int unsigned ERR_W  = mipc_pkg::ERR_W;
  localparam int unsigned PROD_W = mipc_pkg::PROD_W;
  localparam int unsigned CTL_W  = VAL_W + FRAC_BITS;
  localparam int unsigned SUM_W  = ((CTL_W + 1 > PROD_W) ? CTL_W + 1 : PROD_W) + 2;
  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MEM_D  = 1 << ADDR_W;

  // Per-channel state
  logic [CTL_W-1:0]        mem_ctl [MEM_D];
  logic signed [ERR_W-1:0] mem_err [MEM_D];
  logic [MEM_D-1:0]        vld_r;

  // Read stage
  logic                    a_v_r;
  mipc_pkg::item_t         a_item_r;
  logic [CTL_W-1:0]        rd_ctl_r;
  logic signed [ERR_W-1:0] rd_err_r;
  logic                    rd_vld_r;
  logic                    ov_v_r;
  logic [CTL_W-1:0]        ov_ctl_r;
  logic signed [ERR_W-1:0] ov_err_r;
  logic [CTL_W-1:0]        a_ctl;
  logic signed [ERR_W-1:0] a_perr;

  // Multiply stage
  logic                     b_v_r;
  logic [mipc_pkg::CH_W-1:0] b_ch_r;
  mipc_pkg::kind_t          b_kind_r;
  logic signed [ERR_W-1:0]  b_err_r;
  logic [CTL_W-1:0]         b_prev_r;
  logic signed [PROD_W-1:0] b_psum_r;
  logic signed [PROD_W-1:0] b_pprop_r;

  // Output register
  logic                      o_v_r;
  logic [mipc_pkg::CH_W-1:0] o_ch_r;
  logic [VAL_W-1:0]          o_val_r;
  logic [VAL_W-1:0]          o_val_nxt;

  logic                    o_free;
  logic                    b_adv;
  logic                    a_adv;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [ADDR_W-1:0]       a_addr;
  logic [ADDR_W-1:0]       q_addr;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim;
  logic [CTL_W-1:0]        wr_ctl;

  // Stage control: the multiply stage takes an item only when empty
  assign o_free  = !o_v_r || out_ready;
  assign b_adv   = b_v_r && o_free;
  assign a_adv   = a_v_r && !b_v_r;
  assign q_pop   = q_valid && (!a_v_r || a_adv);
  assign wr_en   = b_adv && (b_kind_r == mipc_pkg::KIND_REG);
  assign wr_addr = ADDR_W'(b_ch_r);
  assign a_addr  = ADDR_W'(a_item_r.ch);
  assign q_addr  = ADDR_W'(q_item.ch);

  // Forwarded state wins over the registered read
  always_comb begin
    if (ov_v_r) begin
      a_ctl  = ov_ctl_r;
      a_perr = ov_err_r;
    end else if (rd_vld_r) begin
      a_ctl  = rd_ctl_r;
      a_perr = rd_err_r;
    end else begin
      a_ctl  = '0;
      a_perr = '0;
    end
  end

  // Sum and clamp to 0 .. limit
  assign sum = $signed({{(SUM_W - CTL_W){1'b0}}, b_prev_r})
             + $signed({{(SUM_W - PROD_W){b_psum_r[PROD_W-1]}}, b_psum_r})
             - $signed({{(SUM_W - PROD_W){b_pprop_r[PROD_W-1]}}, b_pprop_r});
  assign lim = $signed({{(SUM_W - CTL_W){1'b0}}, cfg.output_limit, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (sum > lim) begin
      wr_ctl = lim[CTL_W-1:0];
    end else if (sum <= $signed(SUM_W'(0))) begin
      wr_ctl = '0;
    end else begin
      wr_ctl = sum[CTL_W-1:0];
    end
  end

  always_comb begin
    case (b_kind_r)
      mipc_pkg::KIND_REG:   o_val_nxt = wr_ctl[CTL_W-1 -: VAL_W];
      mipc_pkg::KIND_FIXED: o_val_nxt = cfg.fixed_value;
      default:              o_val_nxt = '0;
    endcase
  end

  // State memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ctl[wr_addr] <= wr_ctl;
      mem_err[wr_addr] <= b_err_r;
    end
    if (q_pop) begin
      rd_ctl_r <= mem_ctl[q_addr];
      rd_err_r <= mem_err[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (q_pop) begin
        rd_vld_r <= vld_r[q_addr];
      end
    end
  end

  // Catch a write to the channel held in the read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_v_r <= 1'b0;
    end else if (q_pop) begin
      ov_v_r <= wr_en && (wr_addr == q_addr);
    end else if (wr_en && a_v_r && (wr_addr == a_addr)) begin
      ov_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ov_ctl_r <= wr_ctl;
      ov_err_r <= b_err_r;
    end
  end

  // Advance the read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (q_pop) begin
      a_v_r <= 1'b1;
    end else if (a_adv) begin
      a_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_item_r <= q_item;
    end
  end

  // Advance the multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r    <= 1'b0;
      b_kind_r <= mipc_pkg::KIND_ZERO;
    end else if (a_adv) begin
      b_v_r    <= 1'b1;
      b_kind_r <= a_item_r.kind;
    end else if (b_adv) begin
      b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_ch_r    <= a_item_r.ch;
      b_err_r   <= a_item_r.err;
      b_prev_r  <= a_ctl;
      b_psum_r  <= $signed({1'b0, cfg.gain_sum}) * $signed(a_item_r.err);
      b_pprop_r <= $signed({1'b0, cfg.gain_prop}) * a_perr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (b_adv) begin
      o_v_r <= 1'b1;
    end else if (out_ready) begin
      o_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      o_ch_r  <= b_ch_r;
      o_val_r <= o_val_nxt;
    end
  end

  assign out_valid       = o_v_r;
  assign out_channel     = o_ch_r;
  assign out_control_out = o_val_r;

  // Checks
  a_fwd_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && a_v_r && !q_pop && (wr_addr == a_addr)) |=> ov_v_r)
    else $error("write to channel in read stage not forwarded");

  a_ctl_limit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_ctl} <= {1'b0, cfg.output_limit, {FRAC_BITS{1'b0}}}))
    else $error("stored control value above limit");

  a_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(wr_addr)])
    else $error("written channel not marked valid");

endmodule

`default_nettype wire

### rtl/multichannel_incremental_pi_control.sv
`default_nettype none

// Multichannel velocity-form PI controller. Each transfer on the in_ channel
// updates one channel: error = setpoint - measurement, and the new control
// value is prev_control + gain_sum*error - gain_prop*prev_error in unsigned
// Q.FRAC_BITS, clamped to 0 .. output_limit, stored with the error, and its
// integer part returned on the out_ channel with the channel number. Set
// points below off_threshold and channels at or above CHANNELS return 0, and
// fixed_channel returns fixed_value; neither touches the stored state.
// The multiply stage takes a new update only after the previous one has
// written its channel state back. An update passes through the front
// register, queue, read stage, multiply stage and output register.
// Channel state reads as zero after reset through per-channel valid bits,
// so no clearing pass is needed. Write configuration only while idle.
module multichannel_incremental_pi_control #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mipc_pkg::CH_W-1:0]       in_channel,
  input  wire logic [mipc_pkg::VAL_W-1:0]      in_setpoint,
  input  wire logic [mipc_pkg::VAL_W-1:0]      in_measurement,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [mipc_pkg::CH_W-1:0]            out_channel,
  output logic [mipc_pkg::VAL_W-1:0]           out_control_out,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mipc_pkg::VAL_W-1:0]      cfg_data
);

  mipc_pkg::cfg_t  cfg_r;
  logic            push;
  mipc_pkg::item_t push_item;
  logic            push_ready;
  logic            q_valid;
  mipc_pkg::item_t q_item;
  logic            q_pop;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_sum      <= mipc_pkg::RST_GAIN_SUM;
      cfg_r.gain_prop     <= mipc_pkg::RST_GAIN_PROP;
      cfg_r.off_threshold <= mipc_pkg::RST_OFF_THRESHOLD;
      cfg_r.output_limit  <= mipc_pkg::RST_OUTPUT_LIMIT;
      cfg_r.fixed_channel <= mipc_pkg::RST_FIXED_CHANNEL;
      cfg_r.fixed_value   <= mipc_pkg::RST_FIXED_VALUE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mipc_pkg::REG_GAIN_SUM:      cfg_r.gain_sum      <= cfg_data;
        mipc_pkg::REG_GAIN_PROP:     cfg_r.gain_prop     <= cfg_data;
        mipc_pkg::REG_OFF_THRESHOLD: cfg_r.off_threshold <= cfg_data;
        mipc_pkg::REG_OUTPUT_LIMIT:  cfg_r.output_limit  <= cfg_data;
        mipc_pkg::REG_FIXED_CHANNEL: cfg_r.fixed_channel <= cfg_data[mipc_pkg::CH_W-1:0];
        mipc_pkg::REG_FIXED_VALUE:   cfg_r.fixed_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  mipc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_setpoint    (in_setpoint),
    .in_measurement (in_measurement),
    .push           (push),
    .push_item      (push_item),
    .push_ready     (push_ready)
  );

  mipc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  mipc_back #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_control_out (out_control_out)
  );

endmodule

`default_nettype wire

### verif/mipc_checker.sv
`default_nettype none

module mipc_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [mipc_pkg::CH_W-1:0]       in_channel,
  input  wire logic [mipc_pkg::VAL_W-1:0]      in_setpoint,
  input  wire logic [mipc_pkg::VAL_W-1:0]      in_measurement,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [mipc_pkg::CH_W-1:0]       out_channel,
  input  wire logic [mipc_pkg::VAL_W-1:0]      out_control_out,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [mipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mipc_pkg::VAL_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mipc_pkg::*;

  localparam int CHANNELS  = 8;
  localparam int FRAC_BITS = 12;
  localparam int CTL_W     = VAL_W + FRAC_BITS;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [VAL_W-1:0] drive;
  } drive_rec_t;

  // Mirror of the register file and of the per-channel loop state
  cfg_t                    regs;
  logic [CTL_W-1:0]        last_control [CHANNELS];
  logic signed [ERR_W-1:0] last_error   [CHANNELS];
  drive_rec_t              expected_drive [$];
  int                      faults = 0;

  // Compute the drive value of one update and advance that channel's loop
  function automatic logic [VAL_W-1:0] predict_drive(input logic [CH_W-1:0]  ch,
                                                     input logic [VAL_W-1:0] sp,
                                                     input logic [VAL_W-1:0] meas);
    kind_t            kind;
    longint           err;
    longint           ceiling;
    longint           ctl;
    logic [VAL_W-1:0] drive;
    if (int'(ch) >= CHANNELS || sp < regs.off_threshold) begin
      kind = KIND_ZERO;
    end else if (ch == regs.fixed_channel) begin
      kind = KIND_FIXED;
    end else begin
      kind = KIND_REG;
    end
    drive = '0;
    case (kind)
      KIND_FIXED: begin
        drive = regs.fixed_value;
      end
      KIND_REG: begin
        err = longint'(sp) - longint'(meas);
        ceiling = longint'(regs.output_limit) <<< FRAC_BITS;
        ctl = longint'(last_control[ch])
            + longint'(regs.gain_sum) * err
            - longint'(regs.gain_prop) * longint'(last_error[ch]);
        // Clamp to 0 .. output_limit, zero included at the low end
        if (ctl > ceiling) ctl = ceiling;
        if (ctl <= 0) ctl = 0;
        last_control[ch] = ctl[CTL_W-1:0];
        last_error[ch] = err[ERR_W-1:0];
        drive = ctl[FRAC_BITS +: VAL_W];
      end
      default: begin
        drive = '0;
      end
    endcase
    return drive;
  endfunction

  // Track register writes, predict on input transfers, compare on output transfers
  always @(posedge clk) begin : track
    drive_rec_t want;
    drive_rec_t got;
    if (!rst_n) begin
      regs.gain_sum      = RST_GAIN_SUM;
      regs.gain_prop     = RST_GAIN_PROP;
      regs.off_threshold = RST_OFF_THRESHOLD;
      regs.output_limit  = RST_OUTPUT_LIMIT;
      regs.fixed_channel = RST_FIXED_CHANNEL;
      regs.fixed_value   = RST_FIXED_VALUE;
      for (int i = 0; i < CHANNELS; i++) begin
        last_control[i] = '0;
        last_error[i] = '0;
      end
      expected_drive.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_SUM:      regs.gain_sum = cfg_data;
          REG_GAIN_PROP:     regs.gain_prop = cfg_data;
          REG_OFF_THRESHOLD: regs.off_threshold = cfg_data;
          REG_OUTPUT_LIMIT:  regs.output_limit = cfg_data;
          REG_FIXED_CHANNEL: regs.fixed_channel = cfg_data[CH_W-1:0];
          REG_FIXED_VALUE:   regs.fixed_value = cfg_data;
          default: ;
        endcase
      end

      // Retire the oldest expectation first, then queue the new one
      if (out_valid && out_ready) begin
        got.ch = out_channel;
        got.drive = out_control_out;
        if (expected_drive.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX) begin
            $display("unexpected result: channel %0d drive %0d", got.ch, got.drive);
          end
        end else begin
          want = expected_drive.pop_front();
          if (got.ch !== want.ch || got.drive !== want.drive) begin
            faults++;
            if (faults <= REPORT_MAX) begin
              $display("mismatch: expected channel %0d drive %0d, got channel %0d drive %0d",
                       want.ch, want.drive, got.ch, got.drive);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        want.ch = in_channel;
        want.drive = predict_drive(in_channel, in_setpoint, in_measurement);
        expected_drive.push_back(want);
      end
    end
    pending <= expected_drive.size();
    fail_count <= faults;
  end

endmodule

`default_nettype wire

### verif/tb_multichannel_incremental_pi_control.sv
`default_nettype none

module tb_multichannel_incremental_pi_control;
  timeunit 1ns;
  timeprecision 1ps;

  import mipc_pkg::*;

  localparam int UPDATES_PER_PHASE = 275;
  localparam int RANDOM_PHASES     = 6;
  localparam int CYCLE_LIMIT       = 1_000_000;
  localparam int SETTLE_CYCLES     = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CH_W-1:0]      in_channel = '0;
  logic [VAL_W-1:0]     in_setpoint = '0;
  logic [VAL_W-1:0]     in_measurement = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CH_W-1:0]      out_channel;
  logic [VAL_W-1:0]     out_control_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  int                   stall_left = 0;
  logic                 steady = 1'b0;
  int                   cur_threshold = int'(RST_OFF_THRESHOLD);

  initial begin
    forever #5 clk = ~clk;
  end

  multichannel_incremental_pi_control DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_setpoint     (in_setpoint),
    .in_measurement  (in_measurement),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_control_out (out_control_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  mipc_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_setpoint     (in_setpoint),
    .in_measurement  (in_measurement),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_control_out (out_control_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, none while steady
  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= idle_len();
    end
  end

  // Present one update after an optional gap and hold it until the transfer
  task automatic send_update(input logic [CH_W-1:0]  ch,
                             input logic [VAL_W-1:0] sp,
                             input logic [VAL_W-1:0] meas);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_setpoint <= sp;
    in_measurement <= meas;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for every outstanding result, then let the pipeline drain
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Reprogram all registers with the block idle
  task automatic program_regs(input int gs, input int gp, input int thr,
                              input int lim, input int fch, input int fval);
    in_valid <= 1'b0;
    settle();
    write_reg(REG_GAIN_SUM, VAL_W'(gs));
    write_reg(REG_GAIN_PROP, VAL_W'(gp));
    write_reg(REG_OFF_THRESHOLD, VAL_W'(thr));
    write_reg(REG_OUTPUT_LIMIT, VAL_W'(lim));
    write_reg(REG_FIXED_CHANNEL, VAL_W'(fch));
    write_reg(REG_FIXED_VALUE, VAL_W'(fval));
    cfg_valid <= 1'b0;
    cur_threshold = thr;
  endtask

  // Mostly regulated set points with the measurement near them, plus noise
  task automatic run_updates(input int count);
    logic [CH_W-1:0] ch;
    int              pick;
    int              sp;
    int              meas;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) steady <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) begin
        in_valid <= 1'b0;
        settle();
      end
      ch = CH_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        sp = $urandom_range(0, 65535);
      end else if (pick < 25 && cur_threshold > 0) begin
        sp = $urandom_range(0, cur_threshold - 1);
      end else begin
        sp = cur_threshold + int'($urandom_range(0, 4000));
        if (sp > 65535) sp = 65535;
      end
      if ($urandom_range(0, 9) < 7) begin
        meas = sp + int'($urandom_range(0, 600)) - 300;
        if (meas < 0) meas = 0;
        if (meas > 65535) meas = 65535;
      end else begin
        meas = $urandom_range(0, 65535);
      end
      send_update(ch, VAL_W'(sp), VAL_W'(meas));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: threshold edge, fixed channel, both clamps, zero error
    send_update(3'd0, 16'd409, 16'd0);
    send_update(3'd0, 16'd410, 16'd0);
    send_update(3'd0, 16'd410, 16'd400);
    send_update(3'd6, 16'd410, 16'd0);
    send_update(3'd6, 16'd0, 16'd0);
    send_update(3'd1, 16'hFFFF, 16'd0);
    send_update(3'd2, 16'd410, 16'hFFFF);
    send_update(3'd4, 16'hFFFF, 16'hFFFF);

    // Gains, limit and fixed value at their top values, threshold and fixed channel at zero
    program_regs(65535, 65535, 0, 65535, 0, 65535);
    send_update(3'd1, 16'hFFFF, 16'd0);
    send_update(3'd1, 16'd0, 16'hFFFF);
    send_update(3'd0, 16'd0, 16'd0);
    send_update(3'd2, 16'd1234, 16'd0);
    send_update(3'd2, 16'd0, 16'd1);
    send_update(3'd5, 16'h8000, 16'h7FFF);

    // Gains, limit and fixed value at their bottom values, threshold and fixed channel at their top
    program_regs(0, 0, 65535, 0, 7, 0);
    send_update(3'd7, 16'hFFFF, 16'd0);
    send_update(3'd7, 16'hFFFE, 16'd0);
    send_update(3'd3, 16'hFFFF, 16'd0);
    send_update(3'd3, 16'hFFFF, 16'hFFFF);
    send_update(3'd3, 16'hFFFE, 16'hFFFF);

    // Random settings, each followed by a run of random updates
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 8192),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 6000),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 1000),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(0, 50)
                                               : $urandom_range(0, 65535),
                   $urandom_range(0, 7),
                   $urandom_range(0, 65535));
      run_updates(UPDATES_PER_PHASE);
    end

    in_valid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
